### rtl/efrc_pkg.sv
// Package for the escaped frame receiver: widths, byte codes, result type and CRC step.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package efrc_pkg;

    localparam int LEN_BITS   = 24;
    localparam int COUNT_BITS = 24;

    localparam logic [7:0] CRC_POLY   = 8'h91;
    localparam logic [7:0] ESC_BYTE   = 8'd27;
    localparam logic [7:0] ESC_HEADER = 8'd28;

    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_FRAME_OK = 2'd1;
    localparam logic [1:0] EV_CRC_BAD  = 2'd2;

    localparam logic CFG_HEADER_BYTE = 1'b0;
    localparam logic CFG_CRC_SEED    = 1'b1;

    typedef struct packed {
        logic [1:0]            event_kind;
        logic [7:0]            payload_byte;
        logic [7:0]            frame_type;
        logic [COUNT_BITS-1:0] payload_count;
    } result_t;

    function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (v[0])
            begin
                v = v ^ CRC_POLY;
            end
            v = v >> 1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/efrc_deframer.sv
// Frame state machine: header hunt, length assembly, unescaping and CRC check.
// Depends on efrc_pkg for the CRC step, byte codes and the result type.
`timescale 1ns / 1ps
`default_nettype none

module efrc_deframer
    import efrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] header_byte,
    input  wire logic [7:0] crc_seed,
    output logic            res_valid,
    output result_t         res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_LEN1   = 3'd2;
    localparam logic [2:0] PH_LEN2   = 3'd3;
    localparam logic [2:0] PH_LEN3   = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_CRC    = 3'd6;

    logic [2:0]          phase_reg, phase_next;
    logic                esc_reg, esc_next;
    logic [7:0]          type_reg, type_next;
    logic [7:0]          len0_reg, len0_next;
    logic [7:0]          len1_reg, len1_next;
    logic [LEN_BITS-1:0] length_reg, length_next;
    logic [LEN_BITS-1:0] seen_reg, seen_next;
    logic [LEN_BITS-1:0] emitted_reg, emitted_next;
    logic [7:0]          crc_reg, crc_next;

    logic [7:0] unesc;
    logic [7:0] value;
    logic       esc_start;

    assign unesc     = (rx_byte == ESC_HEADER) ? header_byte : rx_byte;
    assign value     = esc_reg ? unesc : rx_byte;
    assign esc_start = !esc_reg && (rx_byte == ESC_BYTE);

    always_comb
    begin
        phase_next   = phase_reg;
        esc_next     = esc_reg;
        type_next    = type_reg;
        len0_next    = len0_reg;
        len1_next    = len1_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        emitted_next = emitted_reg;
        crc_next     = crc_reg;
        res_valid    = 1'b0;
        res.event_kind   = EV_PAYLOAD;
        res.payload_byte = 8'd0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (rx_byte == header_byte)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_next    = rx_byte;
                esc_next     = 1'b0;
                length_next  = '0;
                seen_next    = '0;
                emitted_next = '0;
                crc_next     = crc_fold(crc_seed, rx_byte);
                phase_next   = PH_LEN1;
            end
            PH_LEN1, PH_LEN2, PH_LEN3:
            begin
                crc_next = crc_fold(crc_reg, rx_byte);
                if (esc_start)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next = 1'b0;
                    if (phase_reg == PH_LEN1)
                    begin
                        len0_next  = value;
                        phase_next = PH_LEN2;
                    end
                    else if (phase_reg == PH_LEN2)
                    begin
                        len1_next  = value;
                        phase_next = PH_LEN3;
                    end
                    else
                    begin
                        length_next = LEN_BITS'({value, len1_reg, len0_reg});
                        seen_next   = '0;
                        phase_next  = (LEN_BITS'({value, len1_reg, len0_reg}) != '0)
                                      ? PH_DATA : PH_CRC;
                    end
                end
            end
            PH_DATA:
            begin
                crc_next  = crc_fold(crc_reg, rx_byte);
                seen_next = seen_reg + 1'b1;
                if (esc_start)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next         = 1'b0;
                    emitted_next     = emitted_reg + 1'b1;
                    res_valid        = 1'b1;
                    res.event_kind   = EV_PAYLOAD;
                    res.payload_byte = value;
                end
                if (seen_next == length_reg)
                begin
                    esc_next   = 1'b0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (esc_start)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next       = 1'b0;
                    phase_next     = PH_HEADER;
                    res_valid      = 1'b1;
                    res.event_kind = (value == crc_reg) ? EV_FRAME_OK : EV_CRC_BAD;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
                esc_next   = 1'b0;
            end
        endcase
        res_valid         = res_valid && accept;
        res.frame_type    = type_next;
        res.payload_count = COUNT_BITS'(emitted_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            esc_reg     <= 1'b0;
            type_reg    <= 8'd0;
            len0_reg    <= 8'd0;
            len1_reg    <= 8'd0;
            length_reg  <= '0;
            seen_reg    <= '0;
            emitted_reg <= '0;
            crc_reg     <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            esc_reg     <= esc_next;
            type_reg    <= type_next;
            len0_reg    <= len0_next;
            len1_reg    <= len1_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            emitted_reg <= emitted_next;
            crc_reg     <= crc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/efrc_out_buf.sv
// Two-entry result buffer between the state machine and the output channel.
// Depends on efrc_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module efrc_out_buf
    import efrc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         space,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      head
);

    logic [1:0] count_reg, count_next;
    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign head      = e0_reg;

    always_comb
    begin
        count_next = count_reg;
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
            begin
                e0_next = push_data;
            end
            else
            begin
                e1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            e0_next    = e1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                e0_next = push_data;
            end
            else
            begin
                e0_next = e1_reg;
                e1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

`default_nettype wire

### rtl/escaped_frame_receiver_crc8_core.sv
// Top level of the escaped frame receiver with CRC-8 check.
// Depends on efrc_pkg, efrc_deframer and efrc_out_buf.
//
// Bytes from the serial link enter on the in_valid / in_ready channel, one
// request per byte. Every accepted request updates the frame state at once and
// may produce one result: an unescaped payload byte, a good-frame event or a
// CRC mismatch event. Results leave on the out_valid / out_ready channel.
// A result is registered into the result buffer as the byte that caused it is
// accepted; bytes that cause no result are simply absorbed.
// Throughput is one byte per cycle while the output side keeps up; the limit
// is the combinational state update with its unrolled eight-step CRC fold.
// A two-entry result buffer decouples the sides: input is still accepted while
// one result waits, and in_ready drops only when both entries are occupied.
// Reset sets header_byte to 126, crc_seed to 0, empties the buffer and returns
// the receiver to header hunting. Registers are written through cfg_we,
// cfg_index and cfg_data, taking effect at the next clock edge, and should be
// written only while no frame is in progress.
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver_crc8_core
    import efrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [7:0]            cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 event_kind,
    output logic [7:0]                 payload_byte,
    output logic [7:0]                 frame_type,
    output logic [COUNT_BITS-1:0]      payload_count
);

    logic [7:0] header_byte_reg;
    logic [7:0] crc_seed_reg;
    logic       accept;
    logic       res_valid;
    result_t    res;
    result_t    head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg <= 8'd126;
            crc_seed_reg    <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_BYTE: header_byte_reg <= cfg_data;
                CFG_CRC_SEED:    crc_seed_reg    <= cfg_data;
                default:         header_byte_reg <= header_byte_reg;
            endcase
        end
    end

    assign accept = in_valid && in_ready;

    efrc_deframer u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .header_byte (header_byte_reg),
        .crc_seed    (crc_seed_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    efrc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign event_kind    = head.event_kind;
    assign payload_byte  = head.payload_byte;
    assign frame_type    = head.frame_type;
    assign payload_count = head.payload_count;

endmodule

`default_nettype wire
